[rtl/core/sard_pkg.sv]
// Shared constants, payload types and control structs of the slot allocator.
`default_nettype none
package sard_pkg;

	localparam int SLOT_COUNT     = 1024;
	localparam int RESERVED_SLOTS = 64;
	localparam int SLOT_LIMIT     = SLOT_COUNT - 2;
	localparam int ADDR_W         = $clog2(SLOT_COUNT);
	localparam int EXT_W          = $clog2(SLOT_COUNT + RESERVED_SLOTS + 1);

	localparam int TIME_W     = 31;
	localparam int MS16_W     = 16;
	localparam int IDX_W      = 10;
	localparam int HW_W       = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	localparam logic [MS16_W-1:0] GRACE_RESET = 16'd2000;
	localparam logic [MS16_W-1:0] DELAY_RESET = 16'd1000;

	localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRACE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY      = 2'd2;

	localparam logic MODE_ALLOC  = 1'b0;
	localparam logic MODE_FREE   = 1'b1;
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [IDX_W-1:0]  slot_index;
		logic [TIME_W-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] granted_slot;
		logic             status;
		logic [HW_W-1:0]  high_water;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic free_slot;
		logic scan_init;
		logic scan_step;
		logic honor;
		logic grant;
		logic grow;
		logic full;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic exhausted;
		logic below_limit;
	} sts_t;

endpackage
`default_nettype wire

[rtl/core/sard_dp.sv]
// Datapath: configuration, slot tables, scan pipeline and result register.
`default_nettype none
module sard_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [sard_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sard_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  wire sard_pkg::in_item_t                   item,
	input  wire sard_pkg::cmd_t                       cmd,
	output sard_pkg::sts_t                            sts,
	output logic                                      done,
	output sard_pkg::out_item_t                       result
);

	logic [sard_pkg::TIME_W-1:0] start_q;
	logic [sard_pkg::MS16_W-1:0] grace_q;
	logic [sard_pkg::MS16_W-1:0] delay_q;

	sard_pkg::in_item_t          item_q;
	logic [sard_pkg::TIME_W:0]   exempt_q;
	logic [sard_pkg::EXT_W-1:0]  extent_q;
	logic [sard_pkg::EXT_W-1:0]  addr_q;
	logic [sard_pkg::EXT_W-1:0]  end_w;
	logic                        in_range;

	logic                        vld_s1;
	logic                        busy_s1;
	logic [sard_pkg::TIME_W-1:0] freed_s1;
	logic [sard_pkg::ADDR_W-1:0] addr_s1;

	logic                        busy_mem  [sard_pkg::SLOT_COUNT];
	logic [sard_pkg::TIME_W-1:0] freed_mem [sard_pkg::SLOT_COUNT];

	logic                        bwe;
	logic [sard_pkg::ADDR_W-1:0] baddr;
	logic                        bdata;

	logic [sard_pkg::TIME_W:0]   age;
	logic                        quar;
	logic                        respond;
	logic                        done_q;
	sard_pkg::out_item_t         result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			grace_q <= sard_pkg::GRACE_RESET;
			delay_q <= sard_pkg::DELAY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sard_pkg::CFG_START_TIME: start_q <= cfg_wdata[sard_pkg::TIME_W-1:0];
				sard_pkg::CFG_GRACE:      grace_q <= cfg_wdata[sard_pkg::MS16_W-1:0];
				sard_pkg::CFG_DELAY:      delay_q <= cfg_wdata[sard_pkg::MS16_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q   <= item;
			exempt_q <= {1'b0, start_q} + {{(sard_pkg::TIME_W + 1 - sard_pkg::MS16_W){1'b0}}, grace_q};
		end
	end

	assign end_w    = (32'(extent_q) < 32'(sard_pkg::SLOT_COUNT)) ? extent_q
	                : sard_pkg::EXT_W'(sard_pkg::SLOT_COUNT);
	assign in_range = 32'(item_q.slot_index) < 32'(sard_pkg::SLOT_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			vld_s1 <= 1'b0;
		end else if (cmd.scan_init) begin
			addr_q <= sard_pkg::EXT_W'(sard_pkg::RESERVED_SLOTS);
			vld_s1 <= 1'b0;
		end else if (cmd.scan_step) begin
			if (addr_q < end_w) begin
				addr_q <= addr_q + sard_pkg::EXT_W'(1);
				vld_s1 <= 1'b1;
			end else begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && (addr_q < end_w)) begin
			busy_s1  <= busy_mem[addr_q[sard_pkg::ADDR_W-1:0]];
			freed_s1 <= freed_mem[addr_q[sard_pkg::ADDR_W-1:0]];
			addr_s1  <= addr_q[sard_pkg::ADDR_W-1:0];
		end
	end

	always_comb begin
		bwe   = 1'b0;
		baddr = addr_s1;
		bdata = 1'b1;
		priority if (cmd.free_slot) begin
			bwe   = in_range;
			baddr = sard_pkg::ADDR_W'(item_q.slot_index);
			bdata = 1'b0;
		end else if (cmd.grant) begin
			bwe = 1'b1;
		end else if (cmd.grow) begin
			bwe   = 1'b1;
			baddr = extent_q[sard_pkg::ADDR_W-1:0];
		end else begin
			bwe = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bwe)
			busy_mem[baddr] <= bdata;
		if (cmd.free_slot && in_range)
			freed_mem[sard_pkg::ADDR_W'(item_q.slot_index)] <= item_q.now_ms;
	end

	assign age  = {1'b0, item_q.now_ms} - {1'b0, freed_s1};
	assign quar = ({1'b0, freed_s1} > exempt_q) &&
	              ($signed(age) < $signed({{(sard_pkg::TIME_W + 1 - sard_pkg::MS16_W){1'b0}},
	                                        delay_q}));

	assign sts.hit         = vld_s1 && !busy_s1 && !(cmd.honor && quar);
	assign sts.exhausted   = !vld_s1 && !(addr_q < end_w);
	assign sts.below_limit = 32'(extent_q) < 32'(sard_pkg::SLOT_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			extent_q <= sard_pkg::EXT_W'(sard_pkg::RESERVED_SLOTS);
		else if (cmd.grow)
			extent_q <= extent_q + sard_pkg::EXT_W'(1);
	end

	assign respond = cmd.free_slot | cmd.grant | cmd.grow | cmd.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= respond;
	end

	always_ff @(posedge clk) begin
		if (respond) begin
			result_q.status     <= sard_pkg::STATUS_DONE;
			result_q.high_water <= sard_pkg::HW_W'(extent_q);
			priority if (cmd.free_slot) begin
				result_q.granted_slot <= item_q.slot_index;
			end else if (cmd.grant) begin
				result_q.granted_slot <= sard_pkg::IDX_W'(addr_s1);
			end else if (cmd.grow) begin
				result_q.granted_slot <= sard_pkg::IDX_W'(extent_q);
				result_q.high_water   <= sard_pkg::HW_W'(extent_q + sard_pkg::EXT_W'(1));
			end else begin
				result_q.granted_slot <= '0;
				result_q.status       <= sard_pkg::STATUS_FULL;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

[rtl/core/sard_ctrl.sv]
// Controller: sequences free, first scan, growth and second scan of one item.
`default_nettype none
module sard_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             mode,
	input  wire sard_pkg::sts_t   sts,
	output sard_pkg::cmd_t        cmd,
	output logic                  busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FREE,
		ST_SCAN1,
		ST_SCAN2
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture   = 1'b1;
					cmd.scan_init = (mode == sard_pkg::MODE_ALLOC);
				end
			end
			ST_FREE: begin
				cmd.free_slot = 1'b1;
			end
			ST_SCAN1: begin
				cmd.honor = 1'b1;
				priority if (sts.hit) begin
					cmd.grant = 1'b1;
				end else if (sts.exhausted) begin
					cmd.grow      = sts.below_limit;
					cmd.scan_init = !sts.below_limit;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_SCAN2: begin
				priority if (sts.hit) begin
					cmd.grant = 1'b1;
				end else if (sts.exhausted) begin
					cmd.full = 1'b1;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= (mode == sard_pkg::MODE_FREE) ? ST_FREE : ST_SCAN1;
				end
				ST_FREE: state_q <= ST_IDLE;
				ST_SCAN1: begin
					if (sts.hit || (sts.exhausted && sts.below_limit))
						state_q <= ST_IDLE;
					else if (sts.exhausted)
						state_q <= ST_SCAN2;
				end
				ST_SCAN2: begin
					if (sts.hit || sts.exhausted)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

[rtl/core/slot_allocator_reuse_delay_core.sv]
// Free: the item is captured, ST_FREE frees the slot and registers the result strobe;
// the next start is taken once the controller is back in idle.
// Allocate: the slot table read port checks one entry per cycle; up to two passes scan the
// used slots, the second only when the first finds none and the used region cannot grow.
// busy stays high until the result strobe is issued; the receiver cannot stall.
// Reset clears configuration to its defaults and the used region to the reserved slots;
// the slot tables are not cleared, entries enter the used region only by being written.
`default_nettype none
module slot_allocator_reuse_delay_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [sard_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sard_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire sard_pkg::in_item_t               item,
	output logic                                  done,
	output sard_pkg::out_item_t                   result
);

	sard_pkg::cmd_t cmd;
	sard_pkg::sts_t sts;

	sard_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (item.mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	sard_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.result    (result)
	);

	a_done_follows_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in progress");

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_full_grants_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == sard_pkg::STATUS_FULL)) |-> (result.granted_slot == '0))
		else $error("full status with nonzero slot");

endmodule
`default_nettype wire

[verif/slot_allocator_reuse_delay_core_tb.sv]
// Self-checking testbench of the slot allocator core: directed table and random mix.
`timescale 1ns / 100ps
module slot_allocator_reuse_delay_core_tb;

	localparam logic [sard_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic                        mode;
		logic [sard_pkg::IDX_W-1:0]  slot;
		logic [sard_pkg::TIME_W-1:0] now;
		bit                          typed;
		sard_pkg::out_item_t         want;
	} dir_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [sard_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sard_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic                            start;
	logic                            busy;
	sard_pkg::in_item_t              item;
	logic                            done;
	sard_pkg::out_item_t             result;

	slot_allocator_reuse_delay_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result)
	);

	// allocator image
	logic [sard_pkg::TIME_W-1:0] session_start_ms;
	logic [sard_pkg::MS16_W-1:0] grace_ms;
	logic [sard_pkg::MS16_W-1:0] delay_ms;
	bit                          slot_taken [sard_pkg::SLOT_COUNT];
	logic [sard_pkg::TIME_W-1:0] slot_freed_ms [sard_pkg::SLOT_COUNT];
	int                          used_top;

	sard_pkg::out_item_t pending_grants [$];
	dir_row_t  steps [21];
	logic [sard_pkg::TIME_W-1:0] cur_ms;
	bit steady;
	int errors;
	int items_sent;
	int n_alloc;
	int n_free;
	int n_full;
	int n_settings;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#150_000_000;
		$display("timeout with %0d results pending", pending_grants.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic bit in_quarantine(input int idx,
			input logic [sard_pkg::TIME_W-1:0] now);
		longint exempt_until;
		longint age;
		exempt_until = longint'(session_start_ms) + longint'(grace_ms);
		if (longint'(slot_freed_ms[idx]) <= exempt_until)
			return 1'b0;
		age = longint'(now) - longint'(slot_freed_ms[idx]);
		return age < longint'(delay_ms);
	endfunction

	function automatic int first_open_slot(input bit honor,
			input logic [sard_pkg::TIME_W-1:0] now);
		int last;
		last = used_top < sard_pkg::SLOT_COUNT ? used_top : sard_pkg::SLOT_COUNT;
		for (int i = sard_pkg::RESERVED_SLOTS; i < last; i++) begin
			if (slot_taken[i])
				continue;
			if (honor && in_quarantine(i, now))
				continue;
			return i;
		end
		return -1;
	endfunction

	function automatic sard_pkg::out_item_t allocate_or_release(input sard_pkg::in_item_t it);
		sard_pkg::out_item_t r;
		int found;
		r = '0;
		r.status = sard_pkg::STATUS_DONE;
		if (it.mode == sard_pkg::MODE_FREE) begin
			slot_taken[it.slot_index] = 1'b0;
			slot_freed_ms[it.slot_index] = it.now_ms;
			r.granted_slot = it.slot_index;
			n_free++;
		end else begin
			n_alloc++;
			found = first_open_slot(1'b1, it.now_ms);
			if (found < 0) begin
				if (used_top < sard_pkg::SLOT_LIMIT) begin
					found = used_top;
					used_top++;
				end else begin
					found = first_open_slot(1'b0, it.now_ms);
				end
			end
			if (found < 0 || found >= sard_pkg::SLOT_COUNT) begin
				r.status = sard_pkg::STATUS_FULL;
				r.granted_slot = '0;
				n_full++;
			end else begin
				slot_taken[found] = 1'b1;
				r.granted_slot = sard_pkg::IDX_W'(found);
			end
		end
		r.high_water = sard_pkg::HW_W'(used_top);
		return r;
	endfunction

	always @(posedge clk) begin
		sard_pkg::out_item_t want;
		if (arst_n && done) begin
			if (pending_grants.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: slot %0d",
					result.granted_slot));
			end else begin
				want = pending_grants.pop_front();
				if (result.granted_slot !== want.granted_slot)
					report_mismatch($sformatf("granted_slot %0d, want %0d",
						result.granted_slot, want.granted_slot));
				if (result.status !== want.status)
					report_mismatch($sformatf("status %0b, want %0b",
						result.status, want.status));
				if (result.high_water !== want.high_water)
					report_mismatch($sformatf("high_water %0d, want %0d",
						result.high_water, want.high_water));
			end
		end
	end

	function automatic sard_pkg::in_item_t mk(input logic m,
			input logic [sard_pkg::IDX_W-1:0] s, input logic [sard_pkg::TIME_W-1:0] t);
		sard_pkg::in_item_t it;
		it.mode = m;
		it.slot_index = s;
		it.now_ms = t;
		return it;
	endfunction

	task automatic send_item(input sard_pkg::in_item_t it, input bit typed,
			input sard_pkg::out_item_t want);
		sard_pkg::out_item_t pred;
		@(negedge clk);
		start = 1'b0;
		while (busy) @(negedge clk);
		while (!steady && $urandom_range(0, 99) < 22) @(negedge clk);
		start = 1'b1;
		item  = it;
		do @(posedge clk); while (busy);
		pred = allocate_or_release(it);
		pending_grants.push_back(typed ? want : pred);
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending_grants.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sard_pkg::CFG_IDX_W-1:0] idx,
			input logic [sard_pkg::CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = d;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			sard_pkg::CFG_START_TIME: session_start_ms = d;
			sard_pkg::CFG_GRACE:      grace_ms = d[sard_pkg::MS16_W-1:0];
			sard_pkg::CFG_DELAY:      delay_ms = d[sard_pkg::MS16_W-1:0];
			default: ;
		endcase
	endtask

	// upper bits of the 16-bit registers carry junk to be dropped
	task automatic program_regs(input logic [sard_pkg::TIME_W-1:0] st,
			input logic [sard_pkg::MS16_W-1:0] gr, input logic [sard_pkg::MS16_W-1:0] dl);
		drain();
		write_reg(sard_pkg::CFG_START_TIME, st);
		write_reg(sard_pkg::CFG_GRACE, {15'($urandom), gr});
		write_reg(sard_pkg::CFG_DELAY, {15'($urandom), dl});
		write_reg(CFG_UNUSED, 31'($urandom));
		n_settings++;
	endtask

	function automatic logic [sard_pkg::IDX_W-1:0] pick_free_slot();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7 && used_top > sard_pkg::RESERVED_SLOTS)
			return sard_pkg::IDX_W'($urandom_range(sard_pkg::RESERVED_SLOTS, used_top - 1));
		if (r < 8)
			return sard_pkg::IDX_W'($urandom_range(0, sard_pkg::RESERVED_SLOTS - 1));
		if (r < 9)
			return sard_pkg::IDX_W'($urandom_range(used_top, sard_pkg::SLOT_COUNT - 1));
		return sard_pkg::IDX_W'($urandom);
	endfunction

	function automatic sard_pkg::in_item_t random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			cur_ms = sard_pkg::TIME_W'($urandom);
		else if (r < 10)
			cur_ms = cur_ms - sard_pkg::TIME_W'($urandom_range(0, 3000));
		else
			cur_ms = cur_ms + sard_pkg::TIME_W'($urandom_range(0, 400));
		if ($urandom_range(0, 1))
			return mk(sard_pkg::MODE_FREE, pick_free_slot(), cur_ms);
		return mk(sard_pkg::MODE_ALLOC, sard_pkg::IDX_W'($urandom), cur_ms);
	endfunction

	task automatic run_mix(input int n);
		repeat (n) send_item(random_item(), 1'b0, '0);
	endtask

	initial begin
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		start     = 1'b0;
		item      = '0;
		arst_n    = 1'b0;
		session_start_ms = '0;
		grace_ms  = sard_pkg::GRACE_RESET;
		delay_ms  = sard_pkg::DELAY_RESET;
		for (int i = 0; i < sard_pkg::SLOT_COUNT; i++) begin
			slot_taken[i] = 1'b0;
			slot_freed_ms[i] = '0;
		end
		used_top   = sard_pkg::RESERVED_SLOTS;
		cur_ms     = 31'd30000;
		steady     = 1'b0;
		errors     = 0;
		items_sent = 0;
		n_alloc    = 0;
		n_free     = 0;
		n_full     = 0;
		n_settings = 1;

		steps = '{
			'{sard_pkg::MODE_ALLOC, 10'd0,    31'd0,    1'b1,
				'{10'd64, sard_pkg::STATUS_DONE, 11'd65}},
			'{sard_pkg::MODE_ALLOC, 10'd1023, 31'd0,    1'b1,
				'{10'd65, sard_pkg::STATUS_DONE, 11'd66}},
			'{sard_pkg::MODE_ALLOC, 10'd0,    31'd10,   1'b1,
				'{10'd66, sard_pkg::STATUS_DONE, 11'd67}},
			'{sard_pkg::MODE_FREE,  10'd65,   31'd500,  1'b1,
				'{10'd65, sard_pkg::STATUS_DONE, 11'd67}},
			'{sard_pkg::MODE_ALLOC, 10'd0,    31'd600,  1'b1,
				'{10'd65, sard_pkg::STATUS_DONE, 11'd67}},
			'{sard_pkg::MODE_FREE,  10'd65,   31'd5000, 1'b1,
				'{10'd65, sard_pkg::STATUS_DONE, 11'd67}},
			'{sard_pkg::MODE_ALLOC, 10'd0,    31'd5100, 1'b1,
				'{10'd67, sard_pkg::STATUS_DONE, 11'd68}},
			'{sard_pkg::MODE_ALLOC, 10'd0,    31'd6000, 1'b1,
				'{10'd65, sard_pkg::STATUS_DONE, 11'd68}},
			'{sard_pkg::MODE_FREE,  10'd66,   31'd9000, 1'b0, '0},
			'{sard_pkg::MODE_ALLOC, 10'd0,    31'd8000, 1'b0, '0},
			'{sard_pkg::MODE_FREE,  10'd0,    31'd0,    1'b1,
				'{10'd0, sard_pkg::STATUS_DONE, 11'd69}},
			'{sard_pkg::MODE_FREE,  10'd63,   31'h7FFFFFFF, 1'b0, '0},
			'{sard_pkg::MODE_FREE,  10'd1023, 31'h7FFFFFFF, 1'b1,
				'{10'd1023, sard_pkg::STATUS_DONE, 11'd69}},
			'{sard_pkg::MODE_FREE,  10'd66,   31'd20000, 1'b0, '0},
			'{sard_pkg::MODE_ALLOC, 10'd0,    31'd20500, 1'b0, '0},
			'{sard_pkg::MODE_ALLOC, 10'd0,    31'h7FFFFFFF, 1'b0, '0},
			'{sard_pkg::MODE_FREE,  10'd64,   31'd2000, 1'b0, '0},
			'{sard_pkg::MODE_ALLOC, 10'd0,    31'd2000, 1'b0, '0},
			'{sard_pkg::MODE_FREE,  10'd64,   31'd2001, 1'b0, '0},
			'{sard_pkg::MODE_ALLOC, 10'd0,    31'd2001, 1'b0, '0},
			'{sard_pkg::MODE_ALLOC, 10'd0,    31'd3001, 1'b0, '0}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (steps[i])
			send_item(mk(steps[i].mode, steps[i].slot, steps[i].now), steps[i].typed,
				steps[i].want);

		program_regs('0, '0, '0);
		run_mix(55);
		program_regs(cur_ms - 31'd500, 16'hFFFF, 16'hFFFF);
		run_mix(55);
		steady = 1'b1;
		program_regs(31'h7FFFFFFF, 16'hFFFF, 16'($urandom));
		run_mix(55);
		steady = 1'b0;
		program_regs(31'($urandom), 16'($urandom), 16'($urandom_range(0, 3000)));
		run_mix(55);

		program_regs(cur_ms, 16'($urandom_range(0, 500)), 16'($urandom_range(0, 3000)));
		run_mix(60);

		drain();
		repeat (16) @(posedge clk);
		$display("covered %0d items: %0d allocations, %0d frees, %0d full answers",
			items_sent, n_alloc, n_free, n_full);
		$display("over %0d register settings, high water reached %0d", n_settings, used_top);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", errors);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
